[src/pds_pkg.sv]
// ============================================================================
// pds_pkg
// Shared types and constants of the priority dispatch scheduler: field widths,
// command and event codes, transaction payloads and the ready table entry.
// ============================================================================
`default_nettype none

package pds_pkg;

   // ready table geometry
   localparam int READY_DEPTH = 16;
   localparam int ADDR_W      = $clog2(READY_DEPTH);
   localparam int OCC_W       = $clog2(READY_DEPTH + 1);

   // field widths
   localparam int PID_W     = 16;
   localparam int WEIGHT_W  = 4;
   localparam int TICKS_W   = 16;
   localparam int MEM_W     = 32;
   localparam int SCORE_W   = 32;
   localparam int SUM_W     = 36;
   localparam int ENTRIES_W = 5;
   localparam int LIMIT_W   = 5;
   localparam int CMP_W     = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

   // score arithmetic: kb = memory / 1024, n = floor(log2 kb) + 1
   localparam int KB_SHIFT = 10;
   localparam int KB_W     = MEM_W - KB_SHIFT;
   localparam int LOG_W    = $clog2(KB_W + 1);
   localparam int PROD_W   = WEIGHT_W + LOG_W;
   localparam int FULL_W   = PROD_W + KB_W;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_READY_LIMIT = '0;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = LIMIT_W'(16);

   typedef enum logic {
      CMD_ADMIT = 1'b0,
      CMD_TICK  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      EVT_ADMITTED   = 3'd0,
      EVT_REFUSED    = 3'd1,
      EVT_COMPLETED  = 3'd2,
      EVT_DISPATCHED = 3'd3,
      EVT_IDLE_TICK  = 3'd4
   } event_kind_type;

   typedef struct packed {
      command_type         command;
      logic [PID_W-1:0]    process_id;
      logic [WEIGHT_W-1:0] rights_weight;
      logic [TICKS_W-1:0]  burst_ticks;
      logic [MEM_W-1:0]    memory_bytes;
   } req_type;

   typedef struct packed {
      event_kind_type       event_kind;
      logic [PID_W-1:0]     event_pid;
      logic [SCORE_W-1:0]   event_priority;
      logic [ENTRIES_W-1:0] ready_entries;
      logic [SUM_W-1:0]     ready_memory_used;
      logic                 last_result;
   } rsp_type;

   typedef struct packed {
      logic [PID_W-1:0]   pid;
      logic [SCORE_W-1:0] score;
      logic [MEM_W-1:0]   memory;
      logic [TICKS_W-1:0] ticks;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

[src/pds_ram.sv]
// ============================================================================
// pds_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module pds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/pds_score.sv]
// ============================================================================
// pds_score
// Score unit: weight * (floor(log2 kb) + 1) * kb with kb = max(memory/1024, 1).
// The logarithm is found one bit per cycle, then two registered multiplies.
// ============================================================================
`default_nettype none

module pds_score (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [pds_pkg::WEIGHT_W-1:0]   weight,
   input  wire logic [pds_pkg::MEM_W-1:0]      memory_bytes,
   output logic                                done,
   output logic      [pds_pkg::SCORE_W-1:0]    score
);

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_LOG,
      SC_MUL_N,
      SC_MUL_KB
   } score_state_type;

   score_state_type                 state_ff, state_in;
   logic [pds_pkg::KB_W-1:0]        kb_ff, kb_in;
   logic [pds_pkg::KB_W-1:0]        shift_ff, shift_in;
   logic [pds_pkg::LOG_W-1:0]       n_ff, n_in;
   logic [pds_pkg::WEIGHT_W-1:0]    weight_ff, weight_in;
   logic [pds_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [pds_pkg::SCORE_W-1:0]     score_ff, score_in;
   logic                            done_ff, done_in;
   logic [pds_pkg::KB_W-1:0]        kb_raw;
   logic [pds_pkg::FULL_W-1:0]      full_prod;

   assign kb_raw    = memory_bytes[pds_pkg::MEM_W-1:pds_pkg::KB_SHIFT];
   assign full_prod = pds_pkg::FULL_W'(prod_ff) * pds_pkg::FULL_W'(kb_ff);

   always_comb begin
      state_in  = state_ff;
      kb_in     = kb_ff;
      shift_in  = shift_ff;
      n_in      = n_ff;
      weight_in = weight_ff;
      prod_in   = prod_ff;
      score_in  = score_ff;
      done_in   = 1'b0;
      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               // clamp kb to at least one
               kb_in     = (kb_raw == '0) ? pds_pkg::KB_W'(1) : kb_raw;
               shift_in  = (kb_raw == '0) ? pds_pkg::KB_W'(1) : kb_raw;
               n_in      = pds_pkg::LOG_W'(1);
               weight_in = weight;
               state_in  = SC_LOG;
            end
         end
         SC_LOG: begin
            if (shift_ff > pds_pkg::KB_W'(1)) begin
               shift_in = shift_ff >> 1;
               n_in     = n_ff + pds_pkg::LOG_W'(1);
            end else begin
               state_in = SC_MUL_N;
            end
         end
         SC_MUL_N: begin
            prod_in  = pds_pkg::PROD_W'(weight_ff) * pds_pkg::PROD_W'(n_ff);
            state_in = SC_MUL_KB;
         end
         SC_MUL_KB: begin
            score_in = pds_pkg::SCORE_W'(full_prod);
            done_in  = 1'b1;
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kb_ff     <= kb_in;
      shift_ff  <= shift_in;
      n_ff      <= n_in;
      weight_ff <= weight_in;
      prod_ff   <= prod_in;
      score_ff  <= score_in;
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done  = done_ff;
   assign score = score_ff;

endmodule

`default_nettype wire

[src/pds_engine.sv]
// ============================================================================
// pds_engine
// Scheduler sequencer: admits into the ready table RAM, counts down the
// running slot, scans the table for the best score, closes the gap behind
// the dispatched entry and hands results to the output register.
// ============================================================================
`default_nettype none

module pds_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pds_pkg::LIMIT_W-1:0]   ready_limit,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire pds_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output pds_pkg::rsp_type                   rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADMIT,
      ST_SCAN,
      ST_SHIFT,
      ST_EMIT_FIRST,
      ST_EMIT_LAST
   } state_type;

   typedef struct packed {
      pds_pkg::event_kind_type       kind;
      logic [pds_pkg::PID_W-1:0]     pid;
      logic [pds_pkg::SCORE_W-1:0]   score;
   } event_type;

   state_type                          state_ff, state_in;
   logic [pds_pkg::OCC_W-1:0]          occ_ff, occ_in;
   logic [pds_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic                               run_valid_ff, run_valid_in;
   logic [pds_pkg::PID_W-1:0]          run_pid_ff, run_pid_in;
   logic [pds_pkg::SCORE_W-1:0]        run_score_ff, run_score_in;
   logic [pds_pkg::TICKS_W-1:0]        run_ticks_ff, run_ticks_in;
   pds_pkg::req_type                   item_ff, item_in;
   logic                               done_ff, done_in;
   event_type                          evt_a_ff, evt_a_in;
   event_type                          evt_b_ff, evt_b_in;
   logic [pds_pkg::OCC_W-1:0]          ptr_ff, ptr_in;
   logic                               cmp_valid_ff, cmp_valid_in;
   logic [pds_pkg::OCC_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [pds_pkg::OCC_W-1:0]          best_idx_ff, best_idx_in;
   pds_pkg::entry_type                 best_ff, best_in;
   logic                               sh_wr_valid_ff, sh_wr_valid_in;
   logic [pds_pkg::ADDR_W-1:0]         sh_wr_addr_ff, sh_wr_addr_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   pds_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                               ram_wr_en;
   logic [pds_pkg::ADDR_W-1:0]         ram_wr_addr;
   pds_pkg::entry_type                 ram_wr_entry;
   logic [pds_pkg::ADDR_W-1:0]         ram_rd_addr;
   logic [pds_pkg::ENTRY_W-1:0]        ram_rd_data;
   pds_pkg::entry_type                 rd_entry;

   logic                               score_start;
   logic                               score_done;
   logic [pds_pkg::SCORE_W-1:0]        score_value;

   logic                               accept;
   logic                               out_free;
   logic [pds_pkg::OCC_W-1:0]          occ_m1;
   logic [pds_pkg::OCC_W-1:0]          ptr_m1;
   logic [pds_pkg::TICKS_W-1:0]        tick_dec;
   logic                               tick_done;
   logic                               run_after;
   logic                               table_full;
   logic                               admit_ok;
   logic                               better;
   logic [pds_pkg::OCC_W-1:0]          best_idx_nx;
   logic                               ptr_more;

   pds_ram #(
      .WIDTH (pds_pkg::ENTRY_W),
      .DEPTH (pds_pkg::READY_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pds_score u_score (
      .clock        (clock),
      .reset        (reset),
      .start        (score_start),
      .weight       (req_data.rights_weight),
      .memory_bytes (req_data.memory_bytes),
      .done         (score_done),
      .score        (score_value)
   );

   assign rd_entry    = pds_pkg::entry_type'(ram_rd_data);
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign req_stall   = (state_ff != ST_IDLE);
   assign score_start = accept && (req_data.command == pds_pkg::CMD_ADMIT);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign occ_m1      = occ_ff - pds_pkg::OCC_W'(1);
   assign ptr_m1      = ptr_ff - pds_pkg::OCC_W'(1);
   assign tick_dec    = (run_ticks_ff != '0) ? run_ticks_ff - pds_pkg::TICKS_W'(1) : '0;
   assign tick_done   = run_valid_ff && (tick_dec == '0);
   assign run_after   = run_valid_ff && !tick_done;
   assign table_full  = (pds_pkg::CMP_W'(occ_ff) >= pds_pkg::CMP_W'(ready_limit))
                        || (occ_ff == pds_pkg::OCC_W'(pds_pkg::READY_DEPTH));
   assign admit_ok    = (occ_ff == '0)
                        || (!table_full && (item_ff.memory_bytes <= rd_entry.memory));
   assign better      = (cmp_idx_ff == '0) || (rd_entry.score > best_ff.score);
   assign best_idx_nx = better ? cmp_idx_ff : best_idx_ff;
   assign ptr_more    = (ptr_ff < occ_ff);

   // read port: pointer while scanning or shifting, else the last entry
   always_comb begin
      case (state_ff)
         ST_SCAN, ST_SHIFT: ram_rd_addr = ptr_ff[pds_pkg::ADDR_W-1:0];
         default:           ram_rd_addr = occ_m1[pds_pkg::ADDR_W-1:0];
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      sum_in         = sum_ff;
      run_valid_in   = run_valid_ff;
      run_pid_in     = run_pid_ff;
      run_score_in   = run_score_ff;
      run_ticks_in   = run_ticks_ff;
      item_in        = item_ff;
      done_in        = done_ff;
      evt_a_in       = evt_a_ff;
      evt_b_in       = evt_b_ff;
      ptr_in         = ptr_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      best_idx_in    = best_idx_ff;
      best_in        = best_ff;
      sh_wr_valid_in = 1'b0;
      sh_wr_addr_in  = sh_wr_addr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = sh_wr_addr_ff;
      ram_wr_entry   = rd_entry;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.command == pds_pkg::CMD_ADMIT) begin
                  state_in = ST_ADMIT;
               end else begin
                  if (run_valid_ff) begin
                     run_ticks_in = tick_dec;
                  end
                  done_in        = tick_done;
                  run_valid_in   = run_after;
                  evt_a_in.kind  = pds_pkg::EVT_COMPLETED;
                  evt_a_in.pid   = run_pid_ff;
                  evt_a_in.score = run_score_ff;
                  if (!run_after && (occ_ff != '0)) begin
                     ptr_in   = '0;
                     state_in = ST_SCAN;
                  end else begin
                     if (tick_done) begin
                        evt_b_in.kind  = pds_pkg::EVT_COMPLETED;
                        evt_b_in.pid   = run_pid_ff;
                        evt_b_in.score = run_score_ff;
                     end else begin
                        evt_b_in.kind  = pds_pkg::EVT_IDLE_TICK;
                        evt_b_in.pid   = '0;
                        evt_b_in.score = '0;
                     end
                     state_in = ST_EMIT_LAST;
                  end
               end
            end
         end

         ST_ADMIT: begin
            // last entry is on the read port; wait for the score
            if (score_done) begin
               if (admit_ok) begin
                  ram_wr_en           = 1'b1;
                  ram_wr_addr         = occ_ff[pds_pkg::ADDR_W-1:0];
                  ram_wr_entry.pid    = item_ff.process_id;
                  ram_wr_entry.score  = score_value;
                  ram_wr_entry.memory = item_ff.memory_bytes;
                  ram_wr_entry.ticks  = item_ff.burst_ticks;
                  occ_in              = occ_ff + pds_pkg::OCC_W'(1);
                  sum_in              = sum_ff + pds_pkg::SUM_W'(item_ff.memory_bytes);
                  evt_b_in.kind       = pds_pkg::EVT_ADMITTED;
               end else begin
                  evt_b_in.kind       = pds_pkg::EVT_REFUSED;
               end
               evt_b_in.pid   = item_ff.process_id;
               evt_b_in.score = score_value;
               state_in       = ST_EMIT_LAST;
            end
         end

         ST_SCAN: begin
            // read one entry per cycle, compare it the cycle after
            if (ptr_more) begin
               ptr_in = ptr_ff + pds_pkg::OCC_W'(1);
            end
            cmp_valid_in = ptr_more;
            cmp_idx_in   = ptr_ff;
            if (cmp_valid_ff) begin
               if (better) begin
                  best_in     = rd_entry;
                  best_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == occ_m1) begin
                  ptr_in   = best_idx_nx + pds_pkg::OCC_W'(1);
                  state_in = ST_SHIFT;
               end
            end
         end

         ST_SHIFT: begin
            // move entry i+1 down to i, one per cycle
            if (sh_wr_valid_ff) begin
               ram_wr_en = 1'b1;
            end
            if (ptr_more) begin
               ptr_in         = ptr_ff + pds_pkg::OCC_W'(1);
               sh_wr_valid_in = 1'b1;
               sh_wr_addr_in  = ptr_m1[pds_pkg::ADDR_W-1:0];
            end else begin
               occ_in         = occ_m1;
               sum_in         = sum_ff - pds_pkg::SUM_W'(best_ff.memory);
               run_valid_in   = 1'b1;
               run_pid_in     = best_ff.pid;
               run_score_in   = best_ff.score;
               run_ticks_in   = best_ff.ticks;
               evt_b_in.kind  = pds_pkg::EVT_DISPATCHED;
               evt_b_in.pid   = best_ff.pid;
               evt_b_in.score = best_ff.score;
               state_in       = done_ff ? ST_EMIT_FIRST : ST_EMIT_LAST;
            end
         end

         ST_EMIT_FIRST: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.event_kind        = evt_a_ff.kind;
               rsp_in.event_pid         = evt_a_ff.pid;
               rsp_in.event_priority    = evt_a_ff.score;
               rsp_in.ready_entries     = pds_pkg::ENTRIES_W'(occ_ff);
               rsp_in.ready_memory_used = sum_ff;
               rsp_in.last_result       = 1'b0;
               state_in                 = ST_EMIT_LAST;
            end
         end

         ST_EMIT_LAST: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.event_kind        = evt_b_ff.kind;
               rsp_in.event_pid         = evt_b_ff.pid;
               rsp_in.event_priority    = evt_b_ff.score;
               rsp_in.ready_entries     = pds_pkg::ENTRIES_W'(occ_ff);
               rsp_in.ready_memory_used = sum_ff;
               rsp_in.last_result       = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      run_pid_ff    <= run_pid_in;
      run_score_ff  <= run_score_in;
      run_ticks_ff  <= run_ticks_in;
      item_ff       <= item_in;
      evt_a_ff      <= evt_a_in;
      evt_b_ff      <= evt_b_in;
      ptr_ff        <= ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      sh_wr_addr_ff <= sh_wr_addr_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         occ_ff         <= '0;
         sum_ff         <= '0;
         run_valid_ff   <= 1'b0;
         done_ff        <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         sh_wr_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         occ_ff         <= occ_in;
         sum_ff         <= sum_in;
         run_valid_ff   <= run_valid_in;
         done_ff        <= done_in;
         cmp_valid_ff   <= cmp_valid_in;
         sh_wr_valid_ff <= sh_wr_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[src/priority_dispatch_scheduler_top.sv]
// ============================================================================
// priority_dispatch_scheduler_top
// Highest-score-first scheduler with a ready table in RAM, one running slot
// and a register port for the ready limit.
// ============================================================================
// One transaction is handled at a time. An admit waits for the score unit,
// which finds the logarithm one bit per cycle and then does two registered
// multiplies. A tick that dispatches walks the ready table through the RAM
// read port to find the best score, then moves each entry behind the winner
// down one place to close the gap. A tick that both completes a process and
// dispatches another reports two results, the completion first. The next
// transaction is taken while the last result still waits in the output
// register. No clearing pass follows reset: only table entries below the
// occupancy are ever used.
`default_nettype none

module priority_dispatch_scheduler_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire pds_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output pds_pkg::rsp_type                       rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pds_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [pds_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [pds_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   logic [pds_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic [pds_pkg::REG_IDX_W-1:0] reg_idx;
   logic                          limit_wr;

   assign reg_idx  = paddr[pds_pkg::CSR_ADDR_W-1:2];
   assign limit_wr = psel && penable && pwrite && (reg_idx == pds_pkg::REG_READY_LIMIT);
   assign limit_in = limit_wr ? pwdata[pds_pkg::LIMIT_W-1:0] : limit_ff;
   assign pready   = 1'b1;
   assign prdata   = (reg_idx == pds_pkg::REG_READY_LIMIT)
                     ? pds_pkg::CSR_DATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= pds_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   pds_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .ready_limit (limit_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // still busy in the cycle after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("transaction taken on two consecutive cycles");

   // only a completion is ever followed by a second result
   a_first_is_completion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |->
         rsp_data.event_kind == pds_pkg::EVT_COMPLETED)
      else $error("non-final result is not a completion");

   // the dispatch follows a taken completion on the next cycle
   a_dispatch_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_result |=>
         rsp_valid && rsp_data.last_result
         && rsp_data.event_kind == pds_pkg::EVT_DISPATCHED)
      else $error("completion not followed by dispatch");

   // reported occupancy never exceeds the table depth
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pds_pkg::CMP_W'(rsp_data.ready_entries)
                    <= pds_pkg::CMP_W'(pds_pkg::READY_DEPTH))
      else $error("ready occupancy above table depth");

endmodule

`default_nettype wire

[test/testbench.sv]
// ============================================================================
// Priority dispatch scheduler regression
// Drives admit and tick transactions into the scheduler, predicts every event
// with a scoreboard model of the ready table and running slot, and compares
// each result field against it. Directed cases come first, then random
// traffic under several ready limits and idling patterns.
// ============================================================================
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PHASE_ITEMS = 192;
   localparam logic [pds_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR =
      {pds_pkg::REG_READY_LIMIT, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pds_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pds_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [pds_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [pds_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [pds_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // scoreboard copy of the scheduler state
   pds_pkg::entry_type sched_table [pds_pkg::READY_DEPTH];
   int unsigned sched_count = 0;
   logic [pds_pkg::SUM_W-1:0] sched_mem_sum = '0;
   pds_pkg::entry_type sched_running;
   logic sched_running_valid = 1'b0;
   logic [pds_pkg::LIMIT_W-1:0] sched_limit = pds_pkg::LIMIT_RESET;
   pds_pkg::rsp_type pending_events [$];

   priority_dispatch_scheduler_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("priority_dispatch_scheduler_top regression: fail");
         $finish;
      end
   end

   // weight * (floor(log2 kb) + 1) * kb, kb at least 1
   function automatic logic [pds_pkg::SCORE_W-1:0] process_score(
         logic [pds_pkg::WEIGHT_W-1:0] weight, logic [pds_pkg::MEM_W-1:0] mem);
      logic [pds_pkg::KB_W-1:0] kb;
      logic [pds_pkg::KB_W-1:0] rest;
      logic [pds_pkg::SCORE_W-1:0] log_term;
      kb = pds_pkg::KB_W'(mem >> pds_pkg::KB_SHIFT);
      if (kb == 0) kb = pds_pkg::KB_W'(1);
      log_term = pds_pkg::SCORE_W'(1);
      rest = kb;
      while (rest > 1) begin
         rest = rest >> 1;
         log_term = log_term + pds_pkg::SCORE_W'(1);
      end
      return pds_pkg::SCORE_W'(weight) * log_term * pds_pkg::SCORE_W'(kb);
   endfunction

   function automatic bit admit_accepted(logic [pds_pkg::MEM_W-1:0] mem);
      int unsigned cap;
      cap = (sched_limit > pds_pkg::READY_DEPTH) ? pds_pkg::READY_DEPTH : sched_limit;
      if (sched_count == 0) return 1'b1;
      if (sched_count >= cap || sched_count >= pds_pkg::READY_DEPTH) return 1'b0;
      return mem <= sched_table[sched_count - 1].memory;
   endfunction

   function automatic void push_event(pds_pkg::event_kind_type kind,
                                      logic [pds_pkg::PID_W-1:0] pid,
                                      logic [pds_pkg::SCORE_W-1:0] score, logic last);
      pds_pkg::rsp_type ev;
      ev.event_kind = kind;
      ev.event_pid = pid;
      ev.event_priority = score;
      ev.ready_entries = pds_pkg::ENTRIES_W'(sched_count);
      ev.ready_memory_used = sched_mem_sum;
      ev.last_result = last;
      pending_events.push_back(ev);
   endfunction

   function automatic void predict_events(pds_pkg::req_type item);
      pds_pkg::entry_type fresh;
      pds_pkg::entry_type finished;
      pds_pkg::entry_type picked;
      bit done;
      int unsigned best;
      int unsigned i;
      if (item.command == pds_pkg::CMD_ADMIT) begin
         fresh.pid = item.process_id;
         fresh.score = process_score(item.rights_weight, item.memory_bytes);
         fresh.memory = item.memory_bytes;
         fresh.ticks = item.burst_ticks;
         if (admit_accepted(item.memory_bytes)) begin
            sched_table[sched_count] = fresh;
            sched_count++;
            sched_mem_sum = sched_mem_sum + pds_pkg::SUM_W'(item.memory_bytes);
            push_event(pds_pkg::EVT_ADMITTED, fresh.pid, fresh.score, 1'b1);
         end else begin
            push_event(pds_pkg::EVT_REFUSED, fresh.pid, fresh.score, 1'b1);
         end
         return;
      end
      done = 1'b0;
      finished = sched_running;
      if (sched_running_valid) begin
         if (sched_running.ticks != 0) sched_running.ticks = sched_running.ticks - 1'b1;
         if (sched_running.ticks == 0) begin
            done = 1'b1;
            finished = sched_running;
            sched_running_valid = 1'b0;
         end
      end
      if (!sched_running_valid && sched_count > 0) begin
         // highest score wins, earliest entry on a tie
         best = 0;
         for (i = 1; i < sched_count; i++) begin
            if (sched_table[i].score > sched_table[best].score) best = i;
         end
         picked = sched_table[best];
         for (i = best; i + 1 < sched_count; i++) sched_table[i] = sched_table[i + 1];
         sched_count--;
         sched_mem_sum = sched_mem_sum - pds_pkg::SUM_W'(picked.memory);
         sched_running = picked;
         sched_running_valid = 1'b1;
         if (done) push_event(pds_pkg::EVT_COMPLETED, finished.pid, finished.score, 1'b0);
         push_event(pds_pkg::EVT_DISPATCHED, picked.pid, picked.score, 1'b1);
      end else if (done) begin
         push_event(pds_pkg::EVT_COMPLETED, finished.pid, finished.score, 1'b1);
      end else begin
         push_event(pds_pkg::EVT_IDLE_TICK, '0, '0, 1'b1);
      end
   endfunction

   function automatic pds_pkg::req_type admit_item(logic [pds_pkg::PID_W-1:0] pid,
                                                   logic [pds_pkg::WEIGHT_W-1:0] weight,
                                                   logic [pds_pkg::TICKS_W-1:0] burst,
                                                   logic [pds_pkg::MEM_W-1:0] mem);
      pds_pkg::req_type item;
      item.command = pds_pkg::CMD_ADMIT;
      item.process_id = pid;
      item.rights_weight = weight;
      item.burst_ticks = burst;
      item.memory_bytes = mem;
      return item;
   endfunction

   // tick payload fields are don't-care, so fill them with noise
   function automatic pds_pkg::req_type tick_item();
      pds_pkg::req_type item;
      item = admit_item(pds_pkg::PID_W'($urandom_range(0, 65535)),
                        pds_pkg::WEIGHT_W'($urandom_range(0, 15)),
                        pds_pkg::TICKS_W'($urandom_range(0, 65535)), $urandom);
      item.command = pds_pkg::CMD_TICK;
      return item;
   endfunction

   // mostly size-ordered admissions; the rest random memory, mostly refused
   function automatic pds_pkg::req_type random_admit();
      logic [pds_pkg::MEM_W-1:0] mem;
      logic [pds_pkg::MEM_W-1:0] last;
      logic [pds_pkg::TICKS_W-1:0] burst;
      if ($urandom_range(0, 99) < 15) begin
         mem = $urandom;
      end else if (sched_count == 0) begin
         mem = ($urandom_range(0, 9) == 0) ? '1 : ($urandom >> $urandom_range(0, 31));
      end else begin
         last = sched_table[sched_count - 1].memory;
         mem = ($urandom_range(0, 3) == 0) ? last : $urandom_range(0, last);
      end
      burst = ($urandom_range(0, 3) != 0) ? pds_pkg::TICKS_W'($urandom_range(0, 3))
                                          : pds_pkg::TICKS_W'($urandom_range(0, 65535));
      // keep accepted bursts short so the running slot keeps turning over
      if (admit_accepted(mem) && burst > 12) burst = pds_pkg::TICKS_W'(burst % 13);
      return admit_item(pds_pkg::PID_W'($urandom_range(0, 65535)),
                        pds_pkg::WEIGHT_W'($urandom_range(0, 15)), burst, mem);
   endfunction

   task automatic send_transaction(pds_pkg::req_type item);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predict_events(item);
   endtask

   task automatic write_ready_limit(logic [pds_pkg::LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LIMIT_ADDR;
      pwdata <= pds_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sched_limit = value;
      // read back
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[pds_pkg::LIMIT_W-1:0] !== value) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("ready_limit readback: expected %0d, got %0d", value,
                     prdata[pds_pkg::LIMIT_W-1:0]);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // limit 0: only an empty table accepts
   task automatic test_limit_zero();
      write_ready_limit(pds_pkg::LIMIT_W'(0));
      send_transaction(admit_item(16'h00A5, 4'd1, 16'd0, 32'h0010_0000));
      send_transaction(admit_item(16'h005A, 4'd2, 16'hFFFF, 32'h0000_0400));
      send_transaction(tick_item());
      send_transaction(tick_item());
      write_ready_limit(pds_pkg::LIMIT_W'(31));
   endtask

   // field extremes, size order refusal, completion plus dispatch on one tick
   task automatic test_admission_rules();
      send_transaction(tick_item());
      send_transaction(admit_item(16'hFFFF, 4'd15, 16'd0, 32'hFFFF_FFFF));
      send_transaction(admit_item(16'h0000, 4'd0, 16'd0, 32'h0000_0000));
      send_transaction(admit_item(16'h0001, 4'd15, 16'hFFFF, 32'h0000_1000));
      repeat (4) send_transaction(tick_item());
   endtask

   // equal scores dispatch in arrival order; countdown ticks report no change
   task automatic test_equal_scores();
      send_transaction(admit_item(16'h0010, 4'd3, 16'd2, 32'h0000_0800));
      send_transaction(admit_item(16'h0011, 4'd3, 16'd2, 32'h0000_0800));
      send_transaction(admit_item(16'h0012, 4'd3, 16'd2, 32'h0000_0800));
      repeat (7) send_transaction(tick_item());
   endtask

   task automatic test_random_traffic(int unsigned count);
      int unsigned admit_pct;
      int unsigned n;
      admit_pct = 50;
      for (n = 0; n < count; n++) begin
         // vary the admit mix so the table both fills and drains
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: admit_pct = 25;
               1: admit_pct = 50;
               default: admit_pct = 75;
            endcase
         end
         if ($urandom_range(0, 99) < admit_pct) send_transaction(random_admit());
         else send_transaction(tick_item());
      end
   endtask

   always @(posedge clock) begin
      pds_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected event: kind %0d pid %h prio %h", rsp_data.event_kind,
                        rsp_data.event_pid, rsp_data.event_priority);
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.event_kind !== want.event_kind ||
                rsp_data.event_pid !== want.event_pid ||
                rsp_data.event_priority !== want.event_priority ||
                rsp_data.ready_entries !== want.ready_entries ||
                rsp_data.ready_memory_used !== want.ready_memory_used ||
                rsp_data.last_result !== want.last_result) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("expected kind %0d pid %h prio %h entries %0d mem %h last %b",
                           want.event_kind, want.event_pid, want.event_priority,
                           want.ready_entries, want.ready_memory_used, want.last_result);
                  $display("got      kind %0d pid %h prio %h entries %0d mem %h last %b",
                           rsp_data.event_kind, rsp_data.event_pid, rsp_data.event_priority,
                           rsp_data.ready_entries, rsp_data.ready_memory_used,
                           rsp_data.last_result);
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(25, 71);
      test_limit_zero();
      test_admission_rules();
      test_equal_scores();

      write_ready_limit(pds_pkg::LIMIT_W'(16));
      test_random_traffic(RANDOM_PHASE_ITEMS);
      write_ready_limit(pds_pkg::LIMIT_W'(1));
      test_random_traffic(RANDOM_PHASE_ITEMS);

      set_idling(71, 25);
      write_ready_limit(pds_pkg::LIMIT_W'(31));
      test_random_traffic(RANDOM_PHASE_ITEMS);
      write_ready_limit(pds_pkg::LIMIT_W'($urandom_range(2, 15)));
      test_random_traffic(RANDOM_PHASE_ITEMS);

      set_idling(0, 0);
      write_ready_limit(pds_pkg::LIMIT_W'(0));
      test_random_traffic(RANDOM_PHASE_ITEMS);
      write_ready_limit(pds_pkg::LIMIT_W'(17));
      test_random_traffic(RANDOM_PHASE_ITEMS);

      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("priority_dispatch_scheduler_top regression: pass");
      end else begin
         $display("priority_dispatch_scheduler_top regression: fail");
      end
      $finish;
   end

endmodule
